/* sv/adm_pkg.sv */
package adm_pkg;

   localparam int LABEL_W = 8;
   localparam int LABEL_N = 256;
   localparam int DEG_W = 6;
   localparam int ARC_W = 12;

   typedef logic [1:0] cmd_type;
   typedef logic [2:0] status_type;
   typedef logic [6:0] vix_type;
   typedef logic [DEG_W-1:0] deg_type;
   typedef logic [ARC_W-1:0] arc_type;
   typedef logic [LABEL_W-1:0] label_type;

   localparam cmd_type CMD_ADD = 2'd0;
   localparam cmd_type CMD_ARC = 2'd1;
   localparam cmd_type CMD_QUERY = 2'd2;

   localparam status_type ST_OK = 3'd0;
   localparam status_type ST_NOT_FOUND = 3'd1;
   localparam status_type ST_SELF_LOOP = 3'd2;
   localparam status_type ST_ARC_EXISTS = 3'd3;
   localparam status_type ST_FULL = 3'd4;

   typedef struct packed {
      cmd_type   cmd;
      label_type label_from;
      label_type label_to;
   } req_type;

   typedef struct packed {
      status_type status;
      vix_type    vertex_index;
      deg_type    in_degree;
      deg_type    out_degree;
      arc_type    arc_total;
   } rsp_type;

endpackage

/* sv/adjacency_matrix_degree_table.sv */
// Graph store: vertex labels plus a presence-bit adjacency matrix with per-vertex
// in/out degree counters, driven by one command per request.
// Request channel: req_data is taken at a rising edge where start is high and
// busy is low. Commands: add vertex, insert arc, query degree.
// Result channel: rsp_valid pulses for one cycle with rsp_data; the receiver
// must take it, there is no stall.
// Result state per command: add vertex and the unused command S_LOOK_A, query
// S_QUERY (S_LOOK_A for an unknown label), insert arc S_WB_T after S_LOOK_A,
// S_LOOK_B, S_ARC_T, S_ARC_H (sooner on errors). busy drops in the result cycle,
// so one request is in flight and the next can be taken as the result goes out.
// The steps follow from the two memories, one read and one write port each: a
// 256-entry label map (label -> highest one-based index) and a vertex memory
// holding each row and its two counters; an arc insert is two lookups plus a
// read-modify-write of both endpoint entries through the one write port.
// Reset: a clearing pass writes every label map entry and every vertex entry to
// zero, one per cycle, with busy high. The APB port (undirected mode at
// address 0) is taken during that pass as at any time.
module adjacency_matrix_degree_table #(
   parameter int MAX_VERTICES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  adm_pkg::req_type  req_data,
   output logic              rsp_valid,
   output adm_pkg::rsp_type  rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   localparam int IW = $clog2(MAX_VERTICES + 1);
   localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int DW = adm_pkg::DEG_W;
   localparam int EW = MAX_VERTICES + 2 * DW;
   localparam int CW = $clog2(adm_pkg::LABEL_N);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOK_A,
      S_LOOK_B,
      S_ARC_T,
      S_ARC_H,
      S_WB_T,
      S_QUERY
   } state_type;

   state_type                  state_ff, state_in;
   adm_pkg::req_type           req_ff, req_in;
   logic [CW-1:0]              clr_ff, clr_in;
   logic [IW-1:0]              count_ff, count_in;
   adm_pkg::arc_type           arc_ff, arc_in;
   logic                       mode_ff, mode_in;
   logic [IW-1:0]              ti_ff, ti_in;
   logic [IW-1:0]              hj_ff, hj_in;
   logic [MAX_VERTICES-1:0]    row_ff, row_in;
   adm_pkg::deg_type           tin_ff, tin_in;
   adm_pkg::deg_type           tout_ff, tout_in;
   logic                       mir_ff, mir_in;
   adm_pkg::rsp_type           rsp_ff, rsp_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   // label map: label -> one-based index of the latest vertex with it
   logic [IW-1:0]              map_mem [adm_pkg::LABEL_N];
   adm_pkg::label_type         map_ra;
   logic [IW-1:0]              map_q;
   logic                       map_we;
   adm_pkg::label_type         map_wa;
   logic [IW-1:0]              map_wd;

   // vertex memory: {row, in count, out count}
   logic [EW-1:0]              vm_mem [MAX_VERTICES];
   logic [AW-1:0]              vm_ra;
   logic [EW-1:0]              vm_q;
   logic                       vm_we;
   logic [AW-1:0]              vm_wa;
   logic [EW-1:0]              vm_wd;

   logic                       cfg_wr;

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_wa] <= map_wd;
      end
      map_q <= map_mem[map_ra];
   end

   always_ff @(posedge clock) begin
      if (vm_we) begin
         vm_mem[vm_wa] <= vm_wd;
      end
      vm_q <= vm_mem[vm_ra];
   end

   assign cfg_wr = psel & penable & pwrite;
   assign pready = 1'b1;
   assign prdata = (paddr[2] == 1'b0) ? {31'd0, mode_ff} : 32'd0;

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      logic [AW-1:0]           ti_a;
      logic [AW-1:0]           hj_a;
      logic [MAX_VERTICES-1:0] row_v;
      logic                    mir_v;

      ti_a = AW'(ti_ff - IW'(1));
      hj_a = AW'(hj_ff - IW'(1));
      row_v = vm_q[EW-1:2*DW];
      mir_v = 1'b0;

      state_in = state_ff;
      req_in = req_ff;
      clr_in = clr_ff;
      count_in = count_ff;
      arc_in = arc_ff;
      mode_in = mode_ff;
      ti_in = ti_ff;
      hj_in = hj_ff;
      row_in = row_ff;
      tin_in = tin_ff;
      tout_in = tout_ff;
      mir_in = mir_ff;
      rsp_in = '0;
      rsp_valid_in = 1'b0;

      map_ra = req_data.label_from;
      map_we = 1'b0;
      map_wa = req_ff.label_from;
      map_wd = '0;
      vm_ra = ti_a;
      vm_we = 1'b0;
      vm_wa = ti_a;
      vm_wd = '0;

      if (cfg_wr && (paddr[2] == 1'b0)) begin
         mode_in = pwdata[0];
      end

      case (state_ff)
         S_CLEAR: begin
            map_we = 1'b1;
            map_wa = clr_ff;
            vm_we = ({1'b0, clr_ff} < (CW + 1)'(MAX_VERTICES));
            vm_wa = AW'(clr_ff);
            clr_in = clr_ff + CW'(1);
            if (clr_ff == CW'(adm_pkg::LABEL_N - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               req_in = req_data;
               state_in = S_LOOK_A;
            end
         end
         S_LOOK_A: begin
            case (req_ff.cmd)
               adm_pkg::CMD_ADD: begin
                  rsp_valid_in = 1'b1;
                  state_in = S_IDLE;
                  if (count_ff == IW'(MAX_VERTICES)) begin
                     rsp_in.status = adm_pkg::ST_FULL;
                  end else begin
                     map_we = 1'b1;
                     map_wd = count_ff + IW'(1);
                     count_in = count_ff + IW'(1);
                     rsp_in.vertex_index = adm_pkg::vix_type'(count_ff + IW'(1));
                  end
               end
               adm_pkg::CMD_ARC: begin
                  ti_in = map_q;
                  if (map_q == '0) begin
                     rsp_in.status = adm_pkg::ST_NOT_FOUND;
                     rsp_valid_in = 1'b1;
                     state_in = S_IDLE;
                  end else begin
                     map_ra = req_ff.label_to;
                     state_in = S_LOOK_B;
                  end
               end
               adm_pkg::CMD_QUERY: begin
                  ti_in = map_q;
                  if (map_q == '0) begin
                     rsp_in.status = adm_pkg::ST_NOT_FOUND;
                     rsp_valid_in = 1'b1;
                     state_in = S_IDLE;
                  end else begin
                     vm_ra = AW'(map_q - IW'(1));
                     state_in = S_QUERY;
                  end
               end
               default: begin
                  rsp_valid_in = 1'b1;
                  state_in = S_IDLE;
               end
            endcase
         end
         S_LOOK_B: begin
            hj_in = map_q;
            if (map_q == '0) begin
               rsp_in.status = adm_pkg::ST_NOT_FOUND;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end else if (map_q == ti_ff) begin
               rsp_in.status = adm_pkg::ST_SELF_LOOP;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               vm_ra = ti_a;
               state_in = S_ARC_T;
            end
         end
         S_ARC_T: begin
            // tail entry is on vm_q
            if (row_v[hj_a]) begin
               rsp_in.status = adm_pkg::ST_ARC_EXISTS;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               row_in = row_v;
               tin_in = vm_q[2*DW-1:DW];
               tout_in = vm_q[DW-1:0];
               vm_ra = hj_a;
               state_in = S_ARC_H;
            end
         end
         S_ARC_H: begin
            // head entry is on vm_q; mirror only if the reverse bit is clear
            mir_v = mode_ff & ~row_v[ti_a];
            if (mir_v) begin
               row_v[ti_a] = 1'b1;
            end
            mir_in = mir_v;
            vm_we = 1'b1;
            vm_wa = hj_a;
            vm_wd = {row_v,
                     vm_q[2*DW-1:DW] + DW'(1),
                     vm_q[DW-1:0] + DW'(mir_v)};
            state_in = S_WB_T;
         end
         S_WB_T: begin
            row_v = row_ff;
            row_v[hj_a] = 1'b1;
            vm_we = 1'b1;
            vm_wa = ti_a;
            vm_wd = {row_v, tin_ff + DW'(mir_ff), tout_ff + DW'(1)};
            arc_in = arc_ff + adm_pkg::arc_type'(1) + adm_pkg::arc_type'(mir_ff);
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         S_QUERY: begin
            rsp_in.vertex_index = adm_pkg::vix_type'(ti_ff);
            rsp_in.in_degree = vm_q[2*DW-1:DW];
            rsp_in.out_degree = vm_q[DW-1:0];
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_in.arc_total = arc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         count_ff <= '0;
         arc_ff <= '0;
         mode_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         count_ff <= count_in;
         arc_ff <= arc_in;
         mode_ff <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      ti_ff <= ti_in;
      hj_ff <= hj_in;
      row_ff <= row_in;
      tin_ff <= tin_in;
      tout_ff <= tout_in;
      mir_ff <= mir_in;
      rsp_ff <= rsp_in;
   end

endmodule
